@@ hdl/hpk_pkg.sv @@
`default_nettype none
package hpk_pkg;

	localparam int unsigned WIN_W = 40;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned CHAR_W = 16;
	localparam int unsigned MAX_CODE = 30;
	localparam logic [CNT_W-1:0] MIN_LEN = 6'd5;
	localparam logic [CNT_W-1:0] MAX_LEN = 6'd30;
	localparam logic [15:0] LIMIT_RESET = 16'd4096;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_OVFL = 2'd2;
	localparam logic [1:0] KIND_HALT = 2'd3;

	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic [7:0] coded_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [1:0]  kind;
		logic [15:0] decoded_count;
		logic        last_of_run;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_MATCH,
		S_FINISH,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic       found;
		logic [7:0] sym;
		logic [4:0] len;
	} match_t;

	localparam logic [29:0] CODE_BITS [256] = '{
	30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,30'hfffffe7,
	30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,30'hfffffeb,
	30'hfffffec,
	30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,
	30'hffffff3,
	30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,
	30'hffffffb,
	30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
	30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
	30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
	30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
	30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
	30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
	30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
	30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
	30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
	30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
	30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
	30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
	30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
	30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
	30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
	30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
	30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
	30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
	30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
	30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
	30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
	30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
	30'h1ffffed,
	30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,
	30'hfffff2,
	30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
	30'h7ffffe5,
	30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
	30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,
	30'h7ffff4,
	30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
	30'h7ffffea,
	30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
	30'h3ffffee
	};

	localparam logic [4:0] CODE_LEN [256] = '{
	13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
	28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
	6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
	5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
	13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
	7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
	15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
	6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
	20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
	24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
	22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
	21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
	26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
	19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
	20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
	26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
	};

endpackage
`default_nettype wire

@@ hdl/hpk_match.sv @@
`default_nettype none
module hpk_match
	import hpk_pkg::*;
(
	input  wire logic [MAX_CODE-1:0] head,
	input  wire logic [CNT_W-1:0]    avail,
	output match_t                   res
);

	// The code is prefix free, so at most one symbol can match the head.
	always_comb begin
		res = '0;
		for (int s = 0; s < 256; s++) begin
			if ({1'b0, CODE_LEN[s]} <= avail &&
			    (head >> (MAX_CODE - CODE_LEN[s])) == CODE_BITS[s]) begin
				res.found = 1'b1;
				res.sym = 8'(s);
				res.len = CODE_LEN[s];
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/hpk_cfg.sv @@
`default_nettype none
module hpk_cfg
	import hpk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [15:0]      limit
);

	logic [15:0] limit_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LIMIT) begin
			prdata = {16'd0, limit_q};
		end
	end

endmodule
`default_nettype wire

@@ hdl/hpack_huffman_decoder.sv @@
// Channel  Direction  Payload  Handshake
// in       input      in_t     in_valid / in_stall
// out      output     out_t    out_valid / out_stall
// cfg      input      limit    APB, register 0 at address 0
//
// Each byte passes through the append, match, finish and flush states (match is skipped while
// halted); the table matcher decodes one symbol per cycle in the match loop while out_stall is low.
// Results go through a one-entry hold register so the last flag can be set.
// in_stall is high whenever a byte is in work; out_stall freezes the loop.
// Reset clears the bit window, counters and the limit (to 4096).
`default_nettype none
module hpack_huffman_decoder
	import hpk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	state_t             state_q, state_d;
	logic [WIN_W-1:0]   win_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CHAR_W-1:0]  char_q;
	logic               halted_q;
	logic [1:0]         n_q;
	logic [7:0]         byte_q;
	logic               last_q;
	logic               pend_valid_q;
	out_t               pend_q;
	logic               out_valid_q;
	out_t               out_q;
	logic [15:0]        limit;
	match_t             m;
	logic               free;
	logic               try_m;
	logic               emit;
	out_t               rec;
	logic               flush;
	out_t               pend_last;
	logic               load_out;

	hpk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	hpk_match u_match (
		.head  (win_q[WIN_W-1 -: MAX_CODE]),
		.avail (cnt_q),
		.res   (m)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign free = !out_valid_q || !out_stall;
	assign try_m = (n_q != 2'd2) && (cnt_q >= MIN_LEN);
	assign load_out = free && ((emit && pend_valid_q) || flush);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_APPEND;
			end
			S_APPEND: begin
				state_d = halted_q ? S_FINISH : S_MATCH;
			end
			S_MATCH: begin
				if (!try_m) begin
					state_d = S_FINISH;
				end else if (free) begin
					if (!(m.found && char_q < limit)) state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!last_q || free) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (!pend_valid_q || free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		rec = '0;
		rec.decoded_count = char_q;
		flush = 1'b0;
		pend_last = pend_q;
		pend_last.last_of_run = 1'b1;
		unique case (state_q)
			S_MATCH: begin
				if (try_m) begin
					if (!m.found) begin
						if (cnt_q >= MAX_LEN) begin
							emit = 1'b1;
							rec.kind = KIND_HALT;
						end
					end else if (char_q >= limit) begin
						emit = 1'b1;
						rec.kind = KIND_OVFL;
					end else begin
						emit = 1'b1;
						rec.kind = KIND_CHAR;
						rec.symbol = m.sym;
						rec.decoded_count = char_q + 16'd1;
					end
				end
			end
			S_FINISH: begin
				if (last_q) begin
					emit = 1'b1;
					rec.kind = KIND_DONE;
				end
			end
			S_FLUSH: begin
				flush = pend_valid_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q <= '0;
			cnt_q <= '0;
			char_q <= '0;
			halted_q <= 1'b0;
			n_q <= '0;
			byte_q <= '0;
			last_q <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= in_data.coded_byte;
						last_q <= in_data.last_byte;
					end
				end
				S_APPEND: begin
					n_q <= '0;
					if (!halted_q) begin
						win_q <= win_q | ({byte_q, 32'd0} >> cnt_q);
						cnt_q <= cnt_q + 6'd8;
					end
				end
				S_MATCH: begin
					if (try_m && free) begin
						if (!m.found || char_q >= limit) begin
							if (emit) begin
								win_q <= '0;
								cnt_q <= '0;
								halted_q <= 1'b1;
							end
						end else begin
							win_q <= win_q << m.len;
							cnt_q <= cnt_q - {1'b0, m.len};
							char_q <= char_q + 16'd1;
							n_q <= n_q + 2'd1;
						end
					end
				end
				S_FINISH: begin
					if (last_q && free) begin
						win_q <= '0;
						cnt_q <= '0;
						char_q <= '0;
						halted_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (emit && free) begin
				pend_q <= rec;
				pend_valid_q <= 1'b1;
			end else if (flush && free) begin
				pend_valid_q <= 1'b0;
			end
			// A held result goes out once the next one exists or the byte is done.
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_q <= flush ? pend_last : pend_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'd37)
		else $error("bit window overfilled");

	ap_halt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> cnt_q == '0)
		else $error("halted with pending bits");

	ap_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_APPEND)
		else $error("accepted byte not appended");

	ap_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("result held while idle");

endmodule
`default_nettype wire
